/* rtl/cca_pkg.sv */
package cca_pkg;

    // Link table entry encodings.
    localparam logic [12:0] LINK_FREE = 13'd0;
    localparam logic [12:0] LINK_LAST = 13'h1FFF;

    // Action codes carried by an input item.
    localparam logic [2:0] ACT_ALLOC  = 3'd0;
    localparam logic [2:0] ACT_READ   = 3'd1;
    localparam logic [2:0] ACT_WRITE  = 3'd2;
    localparam logic [2:0] ACT_FREE   = 3'd3;
    localparam logic [2:0] ACT_FORMAT = 3'd4;

    // Status codes returned in a result item.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNMOUNTED = 3'd1;
    localparam logic [2:0] ST_NOFREE    = 3'd2;
    localparam logic [2:0] ST_RANGE     = 3'd3;
    localparam logic [2:0] ST_BROKEN    = 3'd4;

    // Configuration register indexes.
    localparam logic [0:0] REG_MOUNTED = 1'b0;
    localparam logic [0:0] REG_COUNT   = 1'b1;

    // Reset value of the cluster count register.
    localparam logic [12:0] COUNT_RESET = 13'd4096;

    typedef struct packed {
        logic [2:0]  action;
        logic [11:0] cluster_index;
        logic [12:0] link_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] found_index;
        logic [12:0] link_out;
        logic [12:0] freed_count;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       op_load;
        logic       res_init;
        logic       set_code;
        logic [2:0] code;
        logic       write_op;
        logic       read_idx;
        logic       take_link;
        logic       sg_load;
        logic       gc_init;
        logic       gc_step;
        logic       gmod_step;
        logic       scan_init;
        logic       scan_run;
        logic       take_hit;
        logic       walk_free;
        logic       walk_next;
        logic       sweep_init;
        logic       sweep_step;
        logic       out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       mounted;
        logic [2:0] action;
        logic       idx_ok;
        logic       n_zero;
        logic       hint_ok;
        logic       scan_hit;
        logic       scan_done;
        logic       gc_done;
        logic       sg_ge;
        logic       rd_free;
        logic       rd_last;
        logic       rd_big;
        logic       sweep_last;
    } stat_t;

endpackage

/* rtl/cca_ctrl.sv */
module cca_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  cca_pkg::stat_t stat,
    output cca_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DISPATCH = 4'd2;
    localparam logic [3:0] S_RDWAIT   = 4'd3;
    localparam logic [3:0] S_WALK     = 4'd4;
    localparam logic [3:0] S_GCOUNT   = 4'd5;
    localparam logic [3:0] S_GMOD     = 4'd6;
    localparam logic [3:0] S_START    = 4'd7;
    localparam logic [3:0] S_SCAN     = 4'd8;
    localparam logic [3:0] S_FORMAT   = 4'd9;
    localparam logic [3:0] S_FINISH   = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Next state and command decode.
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op_load = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                cmd.res_init = 1'b1;
                cmd.code     = cca_pkg::ST_OK;
                state_next   = S_FINISH;
                if (!stat.mounted) begin
                    cmd.code = cca_pkg::ST_UNMOUNTED;
                end else begin
                    unique case (stat.action)
                        cca_pkg::ACT_ALLOC: begin
                            cmd.code = cca_pkg::ST_NOFREE;
                            if (!stat.n_zero) begin
                                cmd.sg_load = 1'b1;
                                if (stat.hint_ok) begin
                                    state_next = S_START;
                                end else begin
                                    cmd.gc_init = 1'b1;
                                    state_next  = S_GCOUNT;
                                end
                            end
                        end
                        cca_pkg::ACT_READ: begin
                            if (!stat.idx_ok) begin
                                cmd.code = cca_pkg::ST_RANGE;
                            end else begin
                                cmd.read_idx = 1'b1;
                                state_next   = S_RDWAIT;
                            end
                        end
                        cca_pkg::ACT_WRITE: begin
                            if (!stat.idx_ok) begin
                                cmd.code = cca_pkg::ST_RANGE;
                            end else begin
                                cmd.write_op = 1'b1;
                            end
                        end
                        cca_pkg::ACT_FREE: begin
                            if (!stat.idx_ok) begin
                                cmd.code = cca_pkg::ST_RANGE;
                            end else begin
                                cmd.read_idx = 1'b1;
                                state_next   = S_WALK;
                            end
                        end
                        cca_pkg::ACT_FORMAT: begin
                            cmd.sweep_init = 1'b1;
                            state_next     = S_FORMAT;
                        end
                        default: begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_RDWAIT: begin
                cmd.take_link = 1'b1;
                state_next    = S_FINISH;
            end
            S_WALK: begin
                if (stat.rd_free) begin
                    cmd.set_code = 1'b1;
                    cmd.code     = cca_pkg::ST_BROKEN;
                    state_next   = S_FINISH;
                end else begin
                    cmd.walk_free = 1'b1;
                    if (stat.rd_last) begin
                        state_next = S_FINISH;
                    end else if (stat.rd_big) begin
                        cmd.set_code = 1'b1;
                        cmd.code     = cca_pkg::ST_BROKEN;
                        state_next   = S_FINISH;
                    end else begin
                        cmd.walk_next = 1'b1;
                    end
                end
            end
            S_GCOUNT: begin
                if (stat.gc_done) begin
                    state_next = S_GMOD;
                end else begin
                    cmd.gc_step = 1'b1;
                end
            end
            S_GMOD: begin
                if (stat.sg_ge) begin
                    cmd.gmod_step = 1'b1;
                end else begin
                    state_next = S_START;
                end
            end
            S_START: begin
                cmd.scan_init = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN: begin
                if (stat.scan_hit) begin
                    cmd.take_hit = 1'b1;
                    state_next   = S_FINISH;
                end else if (stat.scan_done) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.scan_run = 1'b1;
                end
            end
            S_FORMAT: begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The result register is full from its load until the item is taken.
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

/* rtl/cca_datapath.sv */
module cca_datapath #(
    parameter int CLUSTERS        = 4096,
    parameter int LINKS_PER_GROUP = 128
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cca_pkg::cmd_t      cmd,
    output cca_pkg::stat_t     stat,
    input  cca_pkg::in_item_t  s_data,
    input  logic               mounted,
    input  logic [12:0]        n_active,
    output cca_pkg::out_item_t m_data
);

    localparam int AW   = $clog2(CLUSTERS);
    localparam int NMAX = (CLUSTERS < 8191) ? CLUSTERS : 8191;
    localparam int GMAX = (NMAX + LINKS_PER_GROUP - 1) / LINKS_PER_GROUP;
    localparam int GW   = $clog2(GMAX + 1);
    localparam int OW   = (LINKS_PER_GROUP > 1) ? $clog2(LINKS_PER_GROUP) : 1;
    localparam int CW   = ((AW > 13) ? AW : 13) + 1;
    localparam int PW   = GW + 13;
    localparam int WW   = (PW > CW) ? PW : CW;

    // Link table storage and its ports.
    logic [12:0]        mem [CLUSTERS];
    logic               we;
    logic [AW-1:0]      wa;
    logic [12:0]        wd;
    logic               re;
    logic [AW-1:0]      ra;
    logic [12:0]        rdq_reg;
    logic               byp_reg;
    logic [12:0]        bypd_reg;
    logic [12:0]        rd_data;

    cca_pkg::in_item_t  op_reg;
    cca_pkg::out_item_t res_reg;
    cca_pkg::out_item_t out_reg;

    logic [AW-1:0]      sw_reg;
    logic [AW-1:0]      cur_reg;
    logic [GW-1:0]      hint_reg;
    logic [GW-1:0]      sg_reg;
    logic [GW-1:0]      gcnt_reg;
    logic [CW-1:0]      gbase_reg;
    logic [AW-1:0]      sa_reg;
    logic [GW-1:0]      grp_reg;
    logic [OW-1:0]      off_reg;
    logic [CW-1:0]      cnt_reg;
    logic               pv_reg;
    logic [AW-1:0]      pa_reg;
    logic [GW-1:0]      pg_reg;

    logic [AW-1:0]      idx_a;
    logic [AW-1:0]      d_a;
    logic [PW-1:0]      hint_prod;
    logic [PW-1:0]      base_prod;
    logic               scan_issue;
    logic               sa_wrap;
    logic               off_wrap;

    assign idx_a     = AW'(op_reg.cluster_index);
    assign d_a       = AW'(rd_data);
    assign rd_data   = byp_reg ? bypd_reg : rdq_reg;
    assign hint_prod = PW'(hint_reg) * PW'(LINKS_PER_GROUP);
    assign base_prod = PW'(sg_reg) * PW'(LINKS_PER_GROUP);
    assign scan_issue = cnt_reg < CW'(n_active);
    assign sa_wrap   = (CW'(sa_reg) + CW'(1)) == CW'(n_active);
    assign off_wrap  = off_reg == OW'(LINKS_PER_GROUP - 1);

    // Status toward the controller.
    always_comb begin
        stat.mounted    = mounted;
        stat.action     = op_reg.action;
        stat.idx_ok     = {1'b0, op_reg.cluster_index} < n_active;
        stat.n_zero     = n_active == 13'd0;
        stat.hint_ok    = WW'(hint_prod) < WW'(n_active);
        stat.scan_hit   = pv_reg && (rd_data == cca_pkg::LINK_FREE);
        stat.scan_done  = !pv_reg && !scan_issue;
        stat.gc_done    = gbase_reg >= CW'(n_active);
        stat.sg_ge      = sg_reg >= gcnt_reg;
        stat.rd_free    = rd_data == cca_pkg::LINK_FREE;
        stat.rd_last    = rd_data == cca_pkg::LINK_LAST;
        stat.rd_big     = rd_data >= n_active;
        stat.sweep_last = sw_reg == AW'(CLUSTERS - 1);
    end

    // Write port select; the controller raises one writer at a time.
    always_comb begin
        we = 1'b0;
        wa = sw_reg;
        wd = cca_pkg::LINK_FREE;
        priority if (cmd.sweep_step) begin
            we = 1'b1;
            wd = (sw_reg == '0) ? cca_pkg::LINK_LAST : cca_pkg::LINK_FREE;
        end else if (cmd.write_op) begin
            we = 1'b1;
            wa = idx_a;
            wd = op_reg.link_value;
        end else if (cmd.take_hit) begin
            we = 1'b1;
            wa = pa_reg;
            wd = cca_pkg::LINK_LAST;
        end else if (cmd.walk_free) begin
            we = 1'b1;
            wa = cur_reg;
        end else begin
            we = 1'b0;
        end
    end

    // Read port select.
    always_comb begin
        re = 1'b0;
        ra = sa_reg;
        priority if (cmd.read_idx) begin
            re = 1'b1;
            ra = idx_a;
        end else if (cmd.walk_next) begin
            re = 1'b1;
            ra = d_a;
        end else if (cmd.scan_run && scan_issue) begin
            re = 1'b1;
        end else begin
            re = 1'b0;
        end
    end

    // Table memory with registered read; a read of the entry written in the
    // same cycle takes the new value through the bypass.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (re) begin
            rdq_reg <= mem[ra];
        end
        byp_reg  <= we && re && (wa == ra);
        bypd_reg <= wd;
    end

    // Control counters and the next-fit hint.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_reg   <= '0;
            hint_reg <= '0;
            pv_reg   <= 1'b0;
        end else begin
            if (cmd.sweep_init) begin
                sw_reg <= '0;
            end else if (cmd.sweep_step) begin
                sw_reg <= sw_reg + AW'(1);
            end
            if (cmd.take_hit) begin
                hint_reg <= pg_reg;
            end
            if (cmd.scan_init) begin
                pv_reg <= 1'b0;
            end else if (cmd.scan_run) begin
                pv_reg <= scan_issue;
            end
        end
    end

    // Working registers of the current item.
    always_ff @(posedge aclk) begin
        if (cmd.op_load) begin
            op_reg <= s_data;
        end
        if (cmd.read_idx) begin
            cur_reg <= idx_a;
        end else if (cmd.walk_next) begin
            cur_reg <= d_a;
        end

        // Group count and stale hint reduction.
        if (cmd.sg_load) begin
            sg_reg <= hint_reg;
        end else if (cmd.gmod_step) begin
            sg_reg <= sg_reg - gcnt_reg;
        end
        if (cmd.gc_init) begin
            gcnt_reg  <= '0;
            gbase_reg <= '0;
        end else if (cmd.gc_step) begin
            gcnt_reg  <= gcnt_reg + GW'(1);
            gbase_reg <= gbase_reg + CW'(LINKS_PER_GROUP);
        end

        // Scan address walks from the start group and wraps at the count.
        if (cmd.scan_init) begin
            sa_reg  <= AW'(base_prod);
            grp_reg <= sg_reg;
            off_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.scan_run && scan_issue) begin
            pa_reg  <= sa_reg;
            pg_reg  <= grp_reg;
            cnt_reg <= cnt_reg + CW'(1);
            if (sa_wrap) begin
                sa_reg  <= '0;
                grp_reg <= '0;
                off_reg <= '0;
            end else if (off_wrap) begin
                sa_reg  <= sa_reg + AW'(1);
                grp_reg <= grp_reg + GW'(1);
                off_reg <= '0;
            end else begin
                sa_reg  <= sa_reg + AW'(1);
                off_reg <= off_reg + OW'(1);
            end
        end

        // Result fields.
        if (cmd.res_init) begin
            res_reg.status      <= cmd.code;
            res_reg.found_index <= '0;
            res_reg.link_out    <= '0;
            res_reg.freed_count <= '0;
        end else begin
            if (cmd.set_code) begin
                res_reg.status <= cmd.code;
            end
            if (cmd.take_link) begin
                res_reg.link_out <= rd_data;
            end
            if (cmd.take_hit) begin
                res_reg.status      <= cca_pkg::ST_OK;
                res_reg.found_index <= 12'(pa_reg);
            end
            if (cmd.walk_free) begin
                res_reg.freed_count <= res_reg.freed_count + 13'd1;
            end
        end

        if (cmd.out_load) begin
            out_reg <= res_reg;
        end
    end

    assign m_data = out_reg;

endmodule

/* rtl/cluster_chain_allocator.sv */
// Channel   Ports                           Direction  Contents
// s_        s_valid, s_ready, s_data        in         action, cluster index, link value
// m_        m_valid, m_ready, m_data        out        status, found index, link, freed count
// cfg_      cfg_we, cfg_index, cfg_data     in         mounted (0), cluster count (1)
//
// One item at a time: accept, decode, then the work, then load the result register. Free
// chain visits the chain entries one after another; allocate checks table entries in turn,
// as the single table read port checks one entry a cycle, after a group count and reduction
// when the hint is beyond the current group count. Format sweeps the whole table.
// After reset the same sweep clears the table, with s_ready low.
// A new item is accepted while the previous result waits on m_ready.
module cluster_chain_allocator #(
    parameter int CLUSTERS        = 4096,
    parameter int LINKS_PER_GROUP = 128
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cca_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output cca_pkg::out_item_t m_data,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [12:0]        cfg_data
);

    localparam int CW = 18;

    logic           mounted_reg;
    logic [12:0]    count_reg;
    logic [12:0]    n_active;
    cca_pkg::cmd_t  cmd;
    cca_pkg::stat_t stat;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mounted_reg <= 1'b0;
            count_reg   <= cca_pkg::COUNT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                cca_pkg::REG_MOUNTED: mounted_reg <= cfg_data[0];
                cca_pkg::REG_COUNT:   count_reg   <= cfg_data;
                default:              mounted_reg <= mounted_reg;
            endcase
        end
    end

    // Clusters in use, bounded by the table size.
    assign n_active = (CW'(count_reg) < CW'(CLUSTERS)) ? count_reg : 13'(CLUSTERS);

    cca_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cca_datapath #(
        .CLUSTERS        (CLUSTERS),
        .LINKS_PER_GROUP (LINKS_PER_GROUP)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_data   (s_data),
        .mounted  (mounted_reg),
        .n_active (n_active),
        .m_data   (m_data)
    );

endmodule

/* test/tb_cluster_chain_allocator.sv */
module tb_cluster_chain_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_CLUSTERS = 4096;
    localparam int GROUP_LEN  = 128;

    // Action codes that the block does not define.
    localparam logic [2:0] ACT_UNDEF_LO = 3'd5;
    localparam logic [2:0] ACT_UNDEF_HI = 3'd7;

    // Random phases: cluster count, mounted flag and number of items.
    localparam int N_PHASES = 12;
    localparam logic [12:0] PH_COUNT [N_PHASES] =
        '{13'd4096, 13'd300, 13'd140, 13'd60, 13'd1, 13'd300,
          13'd8191, 13'd257, 13'd129, 13'd128, 13'd0, 13'd1000};
    localparam bit PH_MOUNT [N_PHASES] = '{1, 1, 1, 1, 1, 0, 1, 1, 1, 1, 1, 1};
    localparam int PH_ITEMS [N_PHASES] =
        '{60, 300, 200, 150, 40, 30, 40, 300, 200, 150, 20, 150};

    // Idle modes: none, sender idle, receiver stalling, both.
    localparam int IDLE_SEND  [4] = '{0, 66, 0, 11};
    localparam int IDLE_STALL [4] = '{0, 0, 66, 11};

    // A directed row is an item with a predicted result, an item with a typed
    // result, or a register write (index in cluster_index, value in link_value).
    typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        cca_pkg::in_item_t  item;
        cca_pkg::out_item_t want;
    } row_t;

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    cca_pkg::in_item_t  s_data    = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    cca_pkg::out_item_t m_data;
    logic               cfg_we    = 1'b0;
    logic [0:0]         cfg_index = cca_pkg::REG_MOUNTED;
    logic [12:0]        cfg_data  = '0;

    // Shadow copy of the block's state and registers.
    logic [12:0] links [N_CLUSTERS];
    int unsigned hint_group;
    bit          is_mounted;
    logic [12:0] cluster_limit;

    cca_pkg::out_item_t pending_results [$];
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          mismatches    = 0;
    int          results_seen  = 0;
    int          items_sent    = 0;
    int          action_seen [8];
    int          status_seen [8];

    cluster_chain_allocator #(
        .CLUSTERS        (N_CLUSTERS),
        .LINKS_PER_GROUP (GROUP_LEN)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Clusters in use: the count register clamped to the table size.
    function automatic int unsigned active_n();
        return (cluster_limit < N_CLUSTERS) ? int'(cluster_limit) : N_CLUSTERS;
    endfunction

    // Applies one item to the shadow state and returns the result it gives.
    function automatic cca_pkg::out_item_t apply_action(cca_pkg::in_item_t it);
        int unsigned n;
        int unsigned groups;
        int unsigned g;
        int unsigned base;
        int unsigned len;
        int unsigned cur;
        int unsigned freed;
        logic [12:0] nxt;
        bit          hit;
        cca_pkg::out_item_t r;
        r = '0;
        n = active_n();
        freed = 0;
        hit = 1'b0;
        if (!is_mounted) begin
            r.status = cca_pkg::ST_UNMOUNTED;
        end else begin
            case (it.action)
                cca_pkg::ACT_ALLOC: begin
                    // Next-fit search by group, first free entry in a group wins.
                    r.status = cca_pkg::ST_NOFREE;
                    groups = (n + GROUP_LEN - 1) / GROUP_LEN;
                    for (int unsigned i = 0; i < groups && !hit; i++) begin
                        g = (hint_group % groups + i) % groups;
                        base = g * GROUP_LEN;
                        len = (n - base > GROUP_LEN) ? GROUP_LEN : n - base;
                        for (int unsigned j = 0; j < len; j++) begin
                            if (links[base + j] == cca_pkg::LINK_FREE) begin
                                links[base + j] = cca_pkg::LINK_LAST;
                                hint_group = g;
                                r.found_index = 12'(base + j);
                                r.status = cca_pkg::ST_OK;
                                hit = 1'b1;
                                break;
                            end
                        end
                    end
                end
                cca_pkg::ACT_READ: begin
                    if (it.cluster_index >= n) r.status = cca_pkg::ST_RANGE;
                    else r.link_out = links[it.cluster_index];
                end
                cca_pkg::ACT_WRITE: begin
                    if (it.cluster_index >= n) r.status = cca_pkg::ST_RANGE;
                    else links[it.cluster_index] = it.link_value;
                end
                cca_pkg::ACT_FREE: begin
                    // Walk the chain, freeing each entry after reading it.
                    if (it.cluster_index >= n) begin
                        r.status = cca_pkg::ST_RANGE;
                    end else begin
                        cur = it.cluster_index;
                        while (1'b1) begin
                            nxt = links[cur];
                            if (nxt == cca_pkg::LINK_FREE) begin
                                r.status = cca_pkg::ST_BROKEN;
                                break;
                            end
                            links[cur] = cca_pkg::LINK_FREE;
                            freed++;
                            if (nxt == cca_pkg::LINK_LAST) break;
                            if (nxt >= n) begin
                                r.status = cca_pkg::ST_BROKEN;
                                break;
                            end
                            cur = nxt;
                        end
                        r.freed_count = 13'(freed);
                    end
                end
                cca_pkg::ACT_FORMAT: begin
                    foreach (links[k]) links[k] = cca_pkg::LINK_FREE;
                    links[0] = cca_pkg::LINK_LAST;
                end
                default: begin
                end
            endcase
        end
        return r;
    endfunction

    function automatic row_t pred_row(logic [2:0] a, logic [11:0] i, logic [12:0] v);
        return '{ROW_PREDICT, '{a, i, v}, '0};
    endfunction

    function automatic row_t typed_row(logic [2:0] a, logic [11:0] i, logic [12:0] v,
                                       logic [2:0] st, logic [11:0] fd,
                                       logic [12:0] lk, logic [12:0] fr);
        return '{ROW_TYPED, '{a, i, v}, '{st, fd, lk, fr}};
    endfunction

    function automatic row_t reg_row(logic [0:0] idx, logic [12:0] val);
        return '{ROW_REG, '{cca_pkg::ACT_ALLOC, {11'd0, idx}, val}, '0};
    endfunction

    // Mostly an index in range, sometimes any 12-bit value.
    function automatic logic [11:0] pick_index();
        int unsigned n;
        n = active_n();
        if (n == 0 || $urandom_range(99) < 15) return 12'($urandom());
        return 12'($urandom_range(n - 1, 0));
    endfunction

    function automatic logic [12:0] pick_link();
        case ($urandom_range(3))
            0:       return cca_pkg::LINK_FREE;
            1:       return cca_pkg::LINK_LAST;
            2:       return {1'b0, pick_index()};
            default: return 13'($urandom());
        endcase
    endfunction

    // Entered and left just after a rising edge. Drives one item, holds it until
    // accepted, then records what the block should answer.
    task automatic send_item(input row_kind_t kind, input cca_pkg::in_item_t it,
                             input cca_pkg::out_item_t want,
                             output cca_pkg::out_item_t got);
        @(negedge aclk);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (s_ready !== 1'b1);
        got = apply_action(it);
        pending_results.push_back((kind == ROW_TYPED) ? want : got);
        items_sent++;
        action_seen[it.action]++;
        status_seen[got.status]++;
    endtask

    task automatic issue(input logic [2:0] a, input logic [11:0] i, input logic [12:0] v,
                         output cca_pkg::out_item_t got);
        send_item(ROW_PREDICT, '{a, i, v}, '0, got);
    endtask

    // Register writes happen only once every outstanding result has come back.
    task automatic reg_write(input logic [0:0] idx, input logic [12:0] val);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        if (idx == cca_pkg::REG_MOUNTED) is_mounted = val[0];
        else cluster_limit = val;
    endtask

    // The receiver stalls at random according to the current mode.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge aclk) begin
        cca_pkg::out_item_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with none outstanding: %p", m_data);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                results_seen++;
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_data.status);
                    mismatches++;
                end
                if (m_data.found_index !== want.found_index) begin
                    $error("found_index: expected %0d, got %0d",
                           want.found_index, m_data.found_index);
                    mismatches++;
                end
                if (m_data.link_out !== want.link_out) begin
                    $error("link_out: expected %0d, got %0d", want.link_out, m_data.link_out);
                    mismatches++;
                end
                if (m_data.freed_count !== want.freed_count) begin
                    $error("freed_count: expected %0d, got %0d",
                           want.freed_count, m_data.freed_count);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #200_000_000;
        $display("** cluster_chain_allocator: FAILED **");
        $finish;
    end

    initial begin
        row_t               rows [$];
        cca_pkg::out_item_t res;
        logic [11:0] chain_heads [$];
        logic [11:0] head;
        logic [11:0] tail;
        logic [11:0] fresh;
        int          start;
        int          pick;
        int          len;
        int          k;

        // Shadow state after reset.
        foreach (links[i]) links[i] = cca_pkg::LINK_FREE;
        links[0] = cca_pkg::LINK_LAST;
        hint_group = 0;
        is_mounted = 1'b0;
        cluster_limit = cca_pkg::COUNT_RESET;
        foreach (action_seen[i]) action_seen[i] = 0;
        foreach (status_seen[i]) status_seen[i] = 0;

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        // The block clears its table after reset before it takes items.
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);

        // Directed part: unmounted, extremes, chain faults, range and format.
        rows = {
            typed_row(cca_pkg::ACT_READ, 12'd0, 13'd0,
                      cca_pkg::ST_UNMOUNTED, 12'd0, 13'd0, 13'd0),
            typed_row(ACT_UNDEF_HI, 12'hFFF, cca_pkg::LINK_LAST,
                      cca_pkg::ST_UNMOUNTED, 12'd0, 13'd0, 13'd0),
            reg_row(cca_pkg::REG_MOUNTED, 13'd1),
            typed_row(cca_pkg::ACT_READ, 12'd0, 13'd0,
                      cca_pkg::ST_OK, 12'd0, cca_pkg::LINK_LAST, 13'd0),
            typed_row(cca_pkg::ACT_ALLOC, 12'd0, 13'd0,
                      cca_pkg::ST_OK, 12'd1, 13'd0, 13'd0),
            typed_row(cca_pkg::ACT_WRITE, 12'd4095, cca_pkg::LINK_LAST,
                      cca_pkg::ST_OK, 12'd0, 13'd0, 13'd0),
            typed_row(cca_pkg::ACT_WRITE, 12'd1, 13'd4095,
                      cca_pkg::ST_OK, 12'd0, 13'd0, 13'd0),
            typed_row(cca_pkg::ACT_FREE, 12'd1, 13'd0,
                      cca_pkg::ST_OK, 12'd0, 13'd0, 13'd2),
            typed_row(cca_pkg::ACT_FREE, 12'd1, 13'd0,
                      cca_pkg::ST_BROKEN, 12'd0, 13'd0, 13'd0),
            typed_row(ACT_UNDEF_LO, 12'd0, 13'd0,
                      cca_pkg::ST_OK, 12'd0, 13'd0, 13'd0),
            reg_row(cca_pkg::REG_COUNT, 13'd200),
            typed_row(cca_pkg::ACT_READ, 12'd200, 13'd0,
                      cca_pkg::ST_RANGE, 12'd0, 13'd0, 13'd0),
            typed_row(cca_pkg::ACT_FREE, 12'd4095, 13'd0,
                      cca_pkg::ST_RANGE, 12'd0, 13'd0, 13'd0),
            typed_row(cca_pkg::ACT_WRITE, 12'd199, 13'd300,
                      cca_pkg::ST_OK, 12'd0, 13'd0, 13'd0),
            typed_row(cca_pkg::ACT_FREE, 12'd199, 13'd0,
                      cca_pkg::ST_BROKEN, 12'd0, 13'd0, 13'd1),
            pred_row(cca_pkg::ACT_WRITE, 12'd10, 13'd11),
            pred_row(cca_pkg::ACT_WRITE, 12'd11, 13'd10),
            typed_row(cca_pkg::ACT_FREE, 12'd10, 13'd0,
                      cca_pkg::ST_BROKEN, 12'd0, 13'd0, 13'd2),
            pred_row(cca_pkg::ACT_WRITE, 12'd5, 13'd5000),
            typed_row(cca_pkg::ACT_FREE, 12'd5, 13'd0,
                      cca_pkg::ST_BROKEN, 12'd0, 13'd0, 13'd1),
            typed_row(cca_pkg::ACT_FORMAT, 12'd0, 13'd0,
                      cca_pkg::ST_OK, 12'd0, 13'd0, 13'd0),
            reg_row(cca_pkg::REG_COUNT, 13'd0),
            typed_row(cca_pkg::ACT_ALLOC, 12'd0, 13'd0,
                      cca_pkg::ST_NOFREE, 12'd0, 13'd0, 13'd0),
            reg_row(cca_pkg::REG_COUNT, 13'd1),
            typed_row(cca_pkg::ACT_ALLOC, 12'd0, 13'd0,
                      cca_pkg::ST_NOFREE, 12'd0, 13'd0, 13'd0),
            typed_row(cca_pkg::ACT_READ, 12'd0, 13'd0,
                      cca_pkg::ST_OK, 12'd0, cca_pkg::LINK_LAST, 13'd0),
            reg_row(cca_pkg::REG_COUNT, 13'd8191),
            typed_row(cca_pkg::ACT_READ, 12'd4095, 13'd0,
                      cca_pkg::ST_OK, 12'd0, 13'd0, 13'd0)
        };
        foreach (rows[i]) begin
            if (rows[i].kind == ROW_REG)
                reg_write(rows[i].item.cluster_index[0:0], rows[i].item.link_value);
            else
                send_item(rows[i].kind, rows[i].item, rows[i].want, res);
        end

        // Random part: mostly chains that are built and later freed, with noise.
        for (int p = 0; p < N_PHASES; p++) begin
            send_idle_pct = IDLE_SEND[p % 4];
            stall_pct     = IDLE_STALL[p % 4];
            reg_write(cca_pkg::REG_MOUNTED, {12'd0, PH_MOUNT[p]});
            reg_write(cca_pkg::REG_COUNT, PH_COUNT[p]);
            start = items_sent;
            while (items_sent - start < PH_ITEMS[p]) begin
                pick = $urandom_range(99);
                if (pick < 40) begin
                    // Allocate a chain and link each new cluster behind the last.
                    len = $urandom_range(6, 1);
                    issue(cca_pkg::ACT_ALLOC, pick_index(), pick_link(), res);
                    if (res.status == cca_pkg::ST_OK) begin
                        head = res.found_index;
                        tail = head;
                        for (k = 1; k < len; k++) begin
                            issue(cca_pkg::ACT_ALLOC, pick_index(), pick_link(), res);
                            if (res.status != cca_pkg::ST_OK) break;
                            fresh = res.found_index;
                            issue(cca_pkg::ACT_WRITE, tail, {1'b0, fresh}, res);
                            tail = fresh;
                        end
                        chain_heads.push_back(head);
                    end
                end else if (pick < 50) begin
                    // A burst of single-cluster files fills the table quickly.
                    len = $urandom_range(24, 4);
                    for (k = 0; k < len; k++) begin
                        issue(cca_pkg::ACT_ALLOC, pick_index(), pick_link(), res);
                        if (res.status == cca_pkg::ST_OK) chain_heads.push_back(res.found_index);
                    end
                end else if (pick < 70 && chain_heads.size() != 0) begin
                    k = $urandom_range(chain_heads.size() - 1, 0);
                    head = chain_heads[k];
                    chain_heads.delete(k);
                    issue(cca_pkg::ACT_FREE, head, pick_link(), res);
                end else if (pick < 78) begin
                    issue(cca_pkg::ACT_READ, pick_index(), pick_link(), res);
                end else if (pick < 88) begin
                    issue(cca_pkg::ACT_WRITE, pick_index(), pick_link(), res);
                end else if (pick < 94) begin
                    issue(cca_pkg::ACT_FREE, pick_index(), pick_link(), res);
                end else if (pick < 98) begin
                    issue(3'($urandom_range(ACT_UNDEF_HI, ACT_UNDEF_LO)), pick_index(),
                          pick_link(), res);
                end else begin
                    issue(cca_pkg::ACT_FORMAT, pick_index(), pick_link(), res);
                    chain_heads.delete();
                end
            end
        end

        // Drain the remaining results and watch for stray ones.
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (64) @(negedge aclk);

        $display("Sent %0d items (%0d allocate, %0d free chain, %0d format),",
                 items_sent, action_seen[cca_pkg::ACT_ALLOC], action_seen[cca_pkg::ACT_FREE],
                 action_seen[cca_pkg::ACT_FORMAT]);
        $display("compared %0d results; ok %0d, not mounted %0d, no free %0d, range %0d, broken %0d.",
                 results_seen, status_seen[cca_pkg::ST_OK], status_seen[cca_pkg::ST_UNMOUNTED],
                 status_seen[cca_pkg::ST_NOFREE], status_seen[cca_pkg::ST_RANGE],
                 status_seen[cca_pkg::ST_BROKEN]);
        if (mismatches == 0) begin
            $display("** cluster_chain_allocator: PASSED **");
        end else begin
            $display("** cluster_chain_allocator: FAILED **");
        end
        $finish;
    end

endmodule
